FILE: design/rbi_pkg.sv
// Shared constants and helpers for the ray/box entry distance pipeline.
package rbi_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int T_WIDTH         = 32;
    localparam int OUT_FIELDS_W    = T_WIDTH + 3;
    localparam int OUT_TDATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    // j-th of the two axes other than a (j = 0 or 1)
    function automatic int other_axis(input int a, input int j);
        int b;
        b = a + 1 + j;
        if (b >= 3)
        begin
            b = b - 3;
        end
        return b;
    endfunction

endpackage

FILE: design/ray_box_intersection.sv
// Ray versus axis-aligned box entry distance, fully pipelined.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+----------------------------------------------
//  s_*      | in  | s_tvalid / s_tready | ray origin, direction, box min/max corners
//  m_*      | out | m_tvalid / m_tready | hit, origin_inside, box_invalid, entry_distance
//
//  One request enters per cycle while the output is not stalled. The pipeline is an input
//  register, a setup stage, the restoring divider with one quotient bit per stage and the three
//  axes side by side, then the multiply, hit point, bounds check and min stages.
//  All stages move together; the pipeline holds while the output is stalled.
//  rst_n clears the valid bits only; payload registers are not reset.
module ray_box_intersection #(
    parameter int COORD_WIDTH = rbi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbi_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, zero pad
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hit, origin_inside, box_invalid, entry_distance[31:0], zero pad
    output logic [rbi_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int CW  = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int TW  = rbi_pkg::T_WIDTH;
    localparam int NW  = CW + 1;
    localparam int RW  = NW + F;
    localparam int XW  = ((RW > CW + TW) ? RW : CW + TW) + 1;
    localparam int PRW = TW + CW;
    localparam int SHW = PRW - F + 1;
    localparam int PW  = SHW + 2;
    localparam logic [PRW:0] RND = (PRW+1)'((64'd1 << F) - 64'd1);

    typedef struct packed {
        logic [2:0][CW-1:0] o;
        logic [2:0][CW-1:0] lo;
        logic [2:0][CW-1:0] hi;
        logic [2:0][CW-1:0] dmag;
        logic [2:0]         dneg;
        logic [2:0]         elig;
        logic               invalid;
        logic               enclosed;
    } ctx_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [TW-1:0] q;
        logic          ovf;
    } div_t;

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // input register
    logic               in_vld_reg;
    logic [12*CW-1:0]   in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s_tvalid)
        begin
            in_reg <= s_tdata[12*CW-1:0];
        end
    end

    // setup: flags, eligible face per axis, numerator and |dir|
    ctx_t         ctx_next;
    div_t [2:0]   dv_next;

    always_comb
    begin
        logic [CW-1:0] o, d, lo, hi;
        logic          low, high;
        logic [NW-1:0] num;
        ctx_next = '0;
        dv_next  = '0;
        for (int a = 0; a < 3; a++)
        begin
            o  = in_reg[a*CW +: CW];
            d  = in_reg[(3+a)*CW +: CW];
            lo = in_reg[(6+a)*CW +: CW];
            hi = in_reg[(9+a)*CW +: CW];
            low  = ($signed(o) < $signed(lo)) && !d[CW-1] && (d != '0);
            high = ($signed(o) > $signed(hi)) && d[CW-1];
            if ($signed(lo) > $signed(hi))
            begin
                ctx_next.invalid = 1'b1;
            end
            ctx_next.o[a]    = o;
            ctx_next.lo[a]   = lo;
            ctx_next.hi[a]   = hi;
            ctx_next.dneg[a] = d[CW-1];
            ctx_next.dmag[a] = d[CW-1] ? (~d + 1'b1) : d;
            ctx_next.elig[a] = low || high;
            num = low ? ({lo[CW-1], lo} - {o[CW-1], o}) : ({o[CW-1], o} - {hi[CW-1], hi});
            dv_next[a].rem = RW'(num) << F;
        end
        ctx_next.enclosed = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(ctx_next.o[a]) < $signed(ctx_next.lo[a]) ||
                $signed(ctx_next.o[a]) > $signed(ctx_next.hi[a]))
            begin
                ctx_next.enclosed = 1'b0;
            end
        end
    end

    logic       vld_reg [0:TW];
    ctx_t       ctx_reg [0:TW];
    div_t [2:0] dv_reg  [0:TW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[0] <= ctx_next;
            dv_reg[0]  <= dv_next;
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    for (genvar k = 0; k < TW; k++)
    begin : g_div
        localparam int BI = TW - 1 - k;
        div_t [2:0] dv_stage;

        always_comb
        begin
            logic [XW-1:0] dsh;
            logic [XW-1:0] r;
            logic          ge;
            for (int a = 0; a < 3; a++)
            begin
                r   = XW'(dv_reg[k][a].rem);
                dsh = XW'(ctx_reg[k].dmag[a]) << BI;
                ge  = r >= dsh;
                dv_stage[a]       = dv_reg[k][a];
                dv_stage[a].rem   = ge ? RW'(r - dsh) : dv_reg[k][a].rem;
                dv_stage[a].q[BI] = ge;
                if (k == 0)
                begin
                    dv_stage[a].ovf = r >= (XW'(ctx_reg[k].dmag[a]) << TW);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctx_reg[k+1] <= ctx_reg[k];
                dv_reg[k+1]  <= dv_stage;
            end
        end
    end

    // multiply: saturated t times |dir| of the two other axes
    logic                      mul_vld_reg;
    ctx_t                      mul_ctx_reg;
    logic [2:0][TW-1:0]        mul_q_reg, mul_q_next;
    logic [2:0][1:0][PRW-1:0]  mul_prod_reg, mul_prod_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            mul_q_next[a] = dv_reg[TW][a].ovf ? '1 : dv_reg[TW][a].q;
            for (int j = 0; j < 2; j++)
            begin
                mul_prod_next[a][j] = PRW'(mul_q_next[a]) *
                    PRW'(ctx_reg[TW].dmag[rbi_pkg::other_axis(a, j)]);
            end
        end
    end

    // hit point coordinates, rounded toward minus infinity
    logic                      pt_vld_reg;
    ctx_t                      pt_ctx_reg;
    logic [2:0][TW-1:0]        pt_q_reg;
    logic [2:0][1:0][PW-1:0]   pt_reg, pt_next;

    always_comb
    begin
        logic [SHW-1:0] sh;
        logic [PW-1:0]  oe;
        int             b;
        for (int a = 0; a < 3; a++)
        begin
            for (int j = 0; j < 2; j++)
            begin
                b  = rbi_pkg::other_axis(a, j);
                oe = PW'($signed(mul_ctx_reg.o[b]));
                if (mul_ctx_reg.dneg[b])
                begin
                    sh = SHW'(({1'b0, mul_prod_reg[a][j]} + RND) >> F);
                    pt_next[a][j] = oe - PW'(sh);
                end
                else
                begin
                    sh = SHW'({1'b0, mul_prod_reg[a][j]} >> F);
                    pt_next[a][j] = oe + PW'(sh);
                end
            end
        end
    end

    // bounds check of the hit point per face
    logic                chk_vld_reg;
    logic                chk_invalid_reg, chk_inside_reg;
    logic [2:0]          chk_pass_reg, chk_pass_next;
    logic [2:0][TW-1:0]  chk_q_reg;

    always_comb
    begin
        int b;
        for (int a = 0; a < 3; a++)
        begin
            chk_pass_next[a] = pt_ctx_reg.elig[a];
            for (int j = 0; j < 2; j++)
            begin
                b = rbi_pkg::other_axis(a, j);
                if ($signed(pt_reg[a][j]) < $signed(PW'($signed(pt_ctx_reg.lo[b]))) ||
                    $signed(pt_reg[a][j]) > $signed(PW'($signed(pt_ctx_reg.hi[b]))))
                begin
                    chk_pass_next[a] = 1'b0;
                end
            end
        end
    end

    // nearest accepted face and result fields
    logic                          out_vld_reg;
    logic [rbi_pkg::OUT_TDATA_W-1:0] out_reg, out_next;

    always_comb
    begin
        logic          found;
        logic [TW-1:0] best;
        found = 1'b0;
        best  = '0;
        for (int a = 0; a < 3; a++)
        begin
            if (chk_pass_reg[a] && (!found || chk_q_reg[a] < best))
            begin
                found = 1'b1;
                best  = chk_q_reg[a];
            end
        end
        out_next = '0;
        if (chk_invalid_reg)
        begin
            out_next[2] = 1'b1;
        end
        else if (chk_inside_reg)
        begin
            out_next[0] = 1'b1;
            out_next[1] = 1'b1;
        end
        else if (found)
        begin
            out_next[0]        = 1'b1;
            out_next[TW+2:3]   = best;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            pt_vld_reg  <= 1'b0;
            chk_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            mul_vld_reg <= vld_reg[TW];
            pt_vld_reg  <= mul_vld_reg;
            chk_vld_reg <= pt_vld_reg;
            out_vld_reg <= chk_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_ctx_reg     <= ctx_reg[TW];
            mul_q_reg       <= mul_q_next;
            mul_prod_reg    <= mul_prod_next;
            pt_ctx_reg      <= mul_ctx_reg;
            pt_q_reg        <= mul_q_reg;
            pt_reg          <= pt_next;
            chk_invalid_reg <= pt_ctx_reg.invalid;
            chk_inside_reg  <= pt_ctx_reg.enclosed;
            chk_pass_reg    <= chk_pass_next;
            chk_q_reg       <= pt_q_reg;
            out_reg         <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_reg;

    a_invalid_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[0] && !m_tdata[1] && (m_tdata[TW+2:3] == '0))
        else $error("invalid box reported with hit or distance");

    a_inside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && (m_tdata[TW+2:3] == '0))
        else $error("inside origin without hit or with nonzero distance");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[TW+2:3] == '0) && !m_tdata[1])
        else $error("miss with nonzero distance");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(chk_vld_reg) && $stable(vld_reg[TW]))
        else $error("pipeline moved during stall");

endmodule
